### rtl/core/vlrl_pkg.sv
// Shared constants and types for the vector length rescale and limit block.
package vlrl_pkg;

    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int FRACTION_BITS_DEF   = 8;
    localparam int QUEUE_DEPTH         = 4;
    localparam int LANES               = 4;

    typedef logic [1:0] opcode_t;

    localparam opcode_t OP_NORMALIZE = 2'd0;
    localparam opcode_t OP_RESCALE   = 2'd1;
    localparam opcode_t OP_LIMIT     = 2'd2;

    typedef struct packed {
        logic zero;
        logic scale;
    } vlrl_flags_t;

endpackage

### rtl/core/vlrl_front.sv
// Front pipeline: takes requests, squares the components and forms the sum of squares.
module vlrl_front #(
    parameter int CW = vlrl_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  vlrl_pkg::opcode_t       in_op,
    input  logic [3:0][CW-1:0]      in_comp,
    input  logic [CW-1:0]           in_target,
    input  logic                    q_ready,
    output logic                    q_push,
    output vlrl_pkg::opcode_t       q_op,
    output logic [3:0][CW-1:0]      q_comp,
    output logic [CW-1:0]           q_target,
    output logic [2*CW:0]           q_sumsq,
    output logic                    q_gt
);
    import vlrl_pkg::*;

    localparam int SW = 2 * CW + 1;

    logic                  en;
    logic                  a_v_reg, b_v_reg, c_v_reg;
    opcode_t               op_a_reg, op_b_reg, op_c_reg;
    logic [3:0][CW-1:0]    comp_a_reg, comp_b_reg, comp_c_reg;
    logic [CW-1:0]         tgt_a_reg, tgt_b_reg, tgt_c_reg;
    logic [3:0][CW-1:0]    mag;
    logic [3:0][2*CW-1:0]  sq_b_reg;
    logic [2*CW-1:0]       t2_b_reg;
    logic [SW-1:0]         sum_next;
    logic [SW-1:0]         sum_c_reg;
    logic                  gt_c_reg;

    assign en       = !c_v_reg || q_ready;
    assign in_ready = en;
    assign q_push   = c_v_reg && q_ready;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            mag[l] = comp_a_reg[l][CW-1] ? (~comp_a_reg[l] + 1'b1) : comp_a_reg[l];
        end
        sum_next = SW'(sq_b_reg[0]) + SW'(sq_b_reg[1]) + SW'(sq_b_reg[2]) + SW'(sq_b_reg[3]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_a_reg   <= in_op;
            comp_a_reg <= in_comp;
            tgt_a_reg  <= in_target;
            op_b_reg   <= op_a_reg;
            comp_b_reg <= comp_a_reg;
            tgt_b_reg  <= tgt_a_reg;
            for (int l = 0; l < 4; l++) begin
                sq_b_reg[l] <= (2*CW)'(mag[l]) * (2*CW)'(mag[l]);
            end
            t2_b_reg   <= (2*CW)'(tgt_a_reg) * (2*CW)'(tgt_a_reg);
            op_c_reg   <= op_b_reg;
            comp_c_reg <= comp_b_reg;
            tgt_c_reg  <= tgt_b_reg;
            sum_c_reg  <= sum_next;
            gt_c_reg   <= sum_next > SW'(t2_b_reg);
        end
    end

    assign q_op     = op_c_reg;
    assign q_comp   = comp_c_reg;
    assign q_target = tgt_c_reg;
    assign q_sumsq  = sum_c_reg;
    assign q_gt     = gt_c_reg;

endmodule

### rtl/core/vlrl_queue.sv
// Short first-in first-out queue between the front and back pipelines.
module vlrl_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = vlrl_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    output logic          in_ready,
    input  logic          pop,
    output logic          out_valid,
    output logic [DW-1:0] out_data
);
    import vlrl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [AW-1:0] head_reg, tail_reg;
    logic [AW:0]   count_reg;

    assign in_ready  = count_reg != (AW+1)'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[head_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                tail_reg <= (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (pop) begin
                head_reg <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/vlrl_sqrt.sv
// Pipelined square root, one result bit per stage, rounded to nearest.
module vlrl_sqrt #(
    parameter int SW = 33,
    parameter int RW = 17,
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [SW-1:0] in_n,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [RW-1:0] out_root,
    output logic [PW-1:0] out_pay
);
    import vlrl_pkg::*;

    localparam int TW = SW + 2;

    logic          v_w    [0:RW];
    logic [SW-1:0] rem_w  [0:RW];
    logic [RW-1:0] root_w [0:RW];
    logic [PW-1:0] pay_w  [0:RW];
    logic          v_fin_reg;
    logic [RW-1:0] root_fin_reg;
    logic [PW-1:0] pay_fin_reg;

    assign v_w[0]    = in_valid;
    assign rem_w[0]  = in_n;
    assign root_w[0] = '0;
    assign pay_w[0]  = in_pay;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic          v_reg;
        logic [SW-1:0] rem_reg;
        logic [RW-1:0] root_reg;
        logic [PW-1:0] pay_reg;
        logic [TW-1:0] trial;
        logic          take;

        always_comb begin
            trial = (TW'(root_w[k]) << (B + 1)) + (TW'(1) << (2 * B));
            take  = TW'(rem_w[k]) >= trial;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg  <= take ? SW'(TW'(rem_w[k]) - trial) : rem_w[k];
                root_reg <= take ? (root_w[k] | (RW'(1) << B)) : root_w[k];
                pay_reg  <= pay_w[k];
            end
        end

        assign v_w[k+1]    = v_reg;
        assign rem_w[k+1]  = rem_reg;
        assign root_w[k+1] = root_reg;
        assign pay_w[k+1]  = pay_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_fin_reg <= 1'b0;
        end else if (en) begin
            v_fin_reg <= v_w[RW];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_fin_reg <= root_w[RW] + RW'(rem_w[RW] > SW'(root_w[RW]));
            pay_fin_reg  <= pay_w[RW];
        end
    end

    assign out_valid = v_fin_reg;
    assign out_root  = root_fin_reg;
    assign out_pay   = pay_fin_reg;

endmodule

### rtl/core/vlrl_div.sv
// Pipelined four-lane restoring divider by a shared divisor, one quotient bit per stage.
module vlrl_div #(
    parameter int NW = 33,
    parameter int RW = 17,
    parameter int PW = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [3:0][NW-1:0] in_num,
    input  logic [RW-1:0]      in_den,
    input  logic [PW-1:0]      in_pay,
    output logic               out_valid,
    output logic [3:0][NW-1:0] out_quo,
    output logic [PW-1:0]      out_pay
);
    import vlrl_pkg::*;

    logic               v_w   [0:NW];
    logic [3:0][NW-1:0] nq_w  [0:NW];
    logic [3:0][RW-1:0] rem_w [0:NW];
    logic [RW-1:0]      den_w [0:NW];
    logic [PW-1:0]      pay_w [0:NW];

    assign v_w[0]   = in_valid;
    assign nq_w[0]  = in_num;
    assign rem_w[0] = '0;
    assign den_w[0] = in_den;
    assign pay_w[0] = in_pay;

    for (genvar k = 0; k < NW; k++) begin : g_stage
        localparam int J = NW - 1 - k;
        logic               v_reg;
        logic [3:0][NW-1:0] nq_reg;
        logic [3:0][RW-1:0] rem_reg;
        logic [RW-1:0]      den_reg;
        logic [PW-1:0]      pay_reg;
        logic [3:0][NW-1:0] nq_next;
        logic [3:0][RW-1:0] rem_next;

        always_comb begin
            for (int l = 0; l < 4; l++) begin
                logic [RW:0] rr;
                logic        ge;
                rr          = {rem_w[k][l], nq_w[k][l][J]};
                ge          = rr >= {1'b0, den_w[k]};
                rem_next[l] = ge ? RW'(rr - {1'b0, den_w[k]}) : RW'(rr);
                nq_next[l]  = nq_w[k][l];
                nq_next[l][J] = ge;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                nq_reg  <= nq_next;
                rem_reg <= rem_next;
                den_reg <= den_w[k];
                pay_reg <= pay_w[k];
            end
        end

        assign v_w[k+1]   = v_reg;
        assign nq_w[k+1]  = nq_reg;
        assign rem_w[k+1] = rem_reg;
        assign den_w[k+1] = den_reg;
        assign pay_w[k+1] = pay_reg;
    end

    assign out_valid = v_w[NW];
    assign out_quo   = nq_w[NW];
    assign out_pay   = pay_w[NW];

endmodule

### rtl/core/vlrl_back.sv
// Back pipeline: length, operation decode, scaling by division and saturation.
module vlrl_back #(
    parameter int CW = vlrl_pkg::COMPONENT_WIDTH_DEF,
    parameter int FB = vlrl_pkg::FRACTION_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    output logic               q_pop,
    input  vlrl_pkg::opcode_t  q_op,
    input  logic [3:0][CW-1:0] q_comp,
    input  logic [CW-1:0]      q_target,
    input  logic [2*CW:0]      q_sumsq,
    input  logic               q_gt,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0][CW-1:0] out_comp,
    output logic [CW:0]        out_len,
    output logic               out_zero,
    output logic               out_scaled
);
    import vlrl_pkg::*;

    localparam int SW  = 2 * CW + 1;
    localparam int RW  = CW + 1;
    localparam int NW  = 2 * CW + 1;
    localparam int PW1 = 4 * CW + CW + 3;
    localparam int PW2 = 4 * CW + 2 + RW;

    logic               en;
    logic               v0_reg;
    opcode_t            op0_reg;
    logic [3:0][CW-1:0] comp0_reg;
    logic [CW-1:0]      tgt0_reg;
    logic [SW-1:0]      sum0_reg;
    logic               gt0_reg;

    logic               s_v;
    logic [RW-1:0]      s_root;
    logic [PW1-1:0]     s_pay;
    opcode_t            s_op;
    logic [3:0][CW-1:0] s_comp;
    logic [CW-1:0]      s_tgt;
    logic               s_gt;
    vlrl_flags_t        s_flags;
    logic [CW-1:0]      s_teff;
    logic [3:0][CW-1:0] s_mag;

    logic               d_v_reg;
    logic [RW-1:0]      d_len_reg;
    vlrl_flags_t        d_flags_reg;
    logic [3:0][CW-1:0] d_comp_reg;
    logic [3:0][CW-1:0] d_mag_reg;
    logic [CW-1:0]      d_teff_reg;

    logic               e_v_reg;
    logic [RW-1:0]      e_len_reg;
    vlrl_flags_t        e_flags_reg;
    logic [3:0][CW-1:0] e_comp_reg;
    logic [3:0][2*CW-1:0] e_prod_reg;

    logic               f_v_reg;
    logic [RW-1:0]      f_len_reg;
    vlrl_flags_t        f_flags_reg;
    logic [3:0][CW-1:0] f_comp_reg;
    logic [3:0][NW-1:0] f_num_reg;

    logic               dv_v;
    logic [3:0][NW-1:0] dv_quo;
    logic [PW2-1:0]     dv_pay;
    logic [RW-1:0]      dv_len;
    vlrl_flags_t        dv_flags;
    logic [3:0][CW-1:0] dv_comp;
    logic [3:0][CW-1:0] res;
    logic [NW-1:0]      maxpos;

    logic               o_v_reg;
    logic [3:0][CW-1:0] o_comp_reg;
    logic [RW-1:0]      o_len_reg;
    vlrl_flags_t        o_flags_reg;

    assign en    = !o_v_reg || out_ready;
    assign q_pop = en && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg  <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end else if (en) begin
            v0_reg  <= q_valid;
            d_v_reg <= s_v;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            o_v_reg <= dv_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op0_reg   <= q_op;
            comp0_reg <= q_comp;
            tgt0_reg  <= q_target;
            sum0_reg  <= q_sumsq;
            gt0_reg   <= q_gt;
        end
    end

    vlrl_sqrt #(
        .SW(SW),
        .RW(RW),
        .PW(PW1)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v0_reg),
        .in_n      (sum0_reg),
        .in_pay    ({gt0_reg, tgt0_reg, comp0_reg, op0_reg}),
        .out_valid (s_v),
        .out_root  (s_root),
        .out_pay   (s_pay)
    );

    always_comb begin
        {s_gt, s_tgt, s_comp, s_op} = s_pay;
        s_flags.zero = s_root == '0;
        unique case (s_op)
            OP_NORMALIZE: s_flags.scale = 1'b1;
            OP_RESCALE:   s_flags.scale = 1'b1;
            OP_LIMIT:     s_flags.scale = s_gt;
            default:      s_flags.scale = 1'b0;
        endcase
        if (s_flags.zero) begin
            s_flags.scale = 1'b0;
        end
        s_teff = (s_op == OP_NORMALIZE) ? CW'(1 << FB) : s_tgt;
        for (int l = 0; l < 4; l++) begin
            s_mag[l] = s_comp[l][CW-1] ? (~s_comp[l] + 1'b1) : s_comp[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_len_reg   <= s_root;
            d_flags_reg <= s_flags;
            d_comp_reg  <= s_comp;
            d_mag_reg   <= s_mag;
            d_teff_reg  <= s_teff;

            e_len_reg   <= d_len_reg;
            e_flags_reg <= d_flags_reg;
            e_comp_reg  <= d_comp_reg;
            for (int l = 0; l < 4; l++) begin
                e_prod_reg[l] <= (2*CW)'(d_mag_reg[l]) * (2*CW)'(d_teff_reg);
            end

            f_len_reg   <= e_len_reg;
            f_flags_reg <= e_flags_reg;
            f_comp_reg  <= e_comp_reg;
            for (int l = 0; l < 4; l++) begin
                f_num_reg[l] <= NW'(e_prod_reg[l]) + NW'(e_len_reg >> 1);
            end
        end
    end

    vlrl_div #(
        .NW(NW),
        .RW(RW),
        .PW(PW2)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_v_reg),
        .in_num    (f_num_reg),
        .in_den    (f_len_reg),
        .in_pay    ({f_len_reg, f_flags_reg, f_comp_reg}),
        .out_valid (dv_v),
        .out_quo   (dv_quo),
        .out_pay   (dv_pay)
    );

    always_comb begin
        {dv_len, dv_flags, dv_comp} = dv_pay;
        maxpos = NW'({1'b0, {(CW-1){1'b1}}});
        for (int l = 0; l < 4; l++) begin
            if (dv_flags.scale) begin
                if (dv_comp[l][CW-1]) begin
                    res[l] = (dv_quo[l] > maxpos) ? {1'b1, {(CW-1){1'b0}}}
                                                  : CW'(~dv_quo[l] + 1'b1);
                end else begin
                    res[l] = (dv_quo[l] > maxpos) ? {1'b0, {(CW-1){1'b1}}}
                                                  : CW'(dv_quo[l]);
                end
            end else if (dv_flags.zero) begin
                res[l] = '0;
            end else begin
                res[l] = dv_comp[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_comp_reg  <= res;
            o_len_reg   <= dv_len;
            o_flags_reg <= dv_flags;
        end
    end

    assign out_valid  = o_v_reg;
    assign out_comp   = o_comp_reg;
    assign out_len    = o_len_reg;
    assign out_zero   = o_flags_reg.zero;
    assign out_scaled = o_flags_reg.scale;

endmodule

### rtl/core/vector4_length_rescale_limit.sv
// Top level of the four-component vector normalize, rescale and length limit block.
// Throughput: one request per cycle while m_tready does not hold the output back; every
// stage is pipelined and no stage iterates. A request passes the front registers, the
// queue, then COMPONENT_WIDTH + 6 square root and decode stages and 2*COMPONENT_WIDTH + 2
// divider and output stages. The divider, one quotient bit per stage, sets most of the
// latency. Reset clears all valid bits and the queue pointers; no clearing pass is needed.
module vector4_length_rescale_limit #(
    parameter int COMPONENT_WIDTH = vlrl_pkg::COMPONENT_WIDTH_DEF,
    parameter int FRACTION_BITS   = vlrl_pkg::FRACTION_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // comp_x, comp_y, comp_z, comp_w, target_length, zero fill
    input  logic [((5*COMPONENT_WIDTH+7)/8)*8-1:0]    s_tdata,
    // opcode
    input  logic [1:0]                                s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // out_x, out_y, out_z, out_w, input_length, zero fill
    output logic [((5*COMPONENT_WIDTH+8)/8)*8-1:0]    m_tdata,
    // zero_vector, was_scaled
    output logic [1:0]                                m_tuser
);
    import vlrl_pkg::*;

    localparam int CW  = COMPONENT_WIDTH;
    localparam int SW  = 2 * CW + 1;
    localparam int OW  = ((5 * CW + 8) / 8) * 8;
    localparam int QDW = 2 + 4 * CW + CW + SW + 1;

    logic [3:0][CW-1:0] in_comp;
    logic               q_push, q_in_ready, q_pop, q_valid;
    opcode_t            f_op, b_op;
    logic [3:0][CW-1:0] f_comp, b_comp;
    logic [CW-1:0]      f_tgt, b_tgt;
    logic [SW-1:0]      f_sum, b_sum;
    logic               f_gt, b_gt;
    logic [QDW-1:0]     q_data;
    logic [3:0][CW-1:0] o_comp;
    logic [CW:0]        o_len;
    logic               o_zero, o_scaled;

    always_comb begin
        for (int l = 0; l < 4; l++) begin
            in_comp[l] = s_tdata[l*CW +: CW];
        end
    end

    vlrl_front #(
        .CW(CW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_comp   (in_comp),
        .in_target (s_tdata[4*CW +: CW]),
        .q_ready   (q_in_ready),
        .q_push    (q_push),
        .q_op      (f_op),
        .q_comp    (f_comp),
        .q_target  (f_tgt),
        .q_sumsq   (f_sum),
        .q_gt      (f_gt)
    );

    vlrl_queue #(
        .DW    (QDW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({f_gt, f_sum, f_tgt, f_comp, f_op}),
        .in_ready  (q_in_ready),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    assign {b_gt, b_sum, b_tgt, b_comp, b_op} = q_data;

    vlrl_back #(
        .CW(CW),
        .FB(FRACTION_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_op       (b_op),
        .q_comp     (b_comp),
        .q_target   (b_tgt),
        .q_sumsq    (b_sum),
        .q_gt       (b_gt),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_comp   (o_comp),
        .out_len    (o_len),
        .out_zero   (o_zero),
        .out_scaled (o_scaled)
    );

    assign m_tdata = OW'({o_len, o_comp});
    assign m_tuser = {o_scaled, o_zero};

endmodule
